>>> rtl/core/gn2d_pkg.sv
// ----------------------------------------------------------------------------
// gn2d_pkg
// shared constants and helpers for the 2d gradient noise pipeline
// ----------------------------------------------------------------------------
package gn2d_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned NoiseW   = 16;
  localparam int unsigned CordicN  = 17;
  localparam logic [31:0] HashMulY = 32'd57;
  localparam logic [31:0] HashK1   = 32'd15731;
  localparam logic [31:0] HashK2   = 32'd789221;
  localparam logic [31:0] HashK3   = 32'd1376312589;
  localparam longint      CordicGainQ30 = 64'sd652032874;

  // arctangent steps in units of 2^-24 turn
  function automatic longint atan_turn24(input int unsigned k);
    longint r;
    case (k)
      0: r = 2097152;  1: r = 1238021;  2: r = 654136;  3: r = 332050;
      4: r = 166669;   5: r = 83416;    6: r = 41718;   7: r = 20860;
      8: r = 10430;    9: r = 5215;     10: r = 2608;   11: r = 1304;
      12: r = 652;     13: r = 326;     14: r = 163;    15: r = 81;
      default: r = 41;
    endcase
    return r;
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint r;
    r = v;
    if (v > 32767) r = 32767;
    if (v < -32767) r = -32767;
    return r;
  endfunction

  // gradient x/y packed {gy, gx}, evaluated at elaboration for the table
  function automatic logic [31:0] grad_entry(input int unsigned idx, input int unsigned abits);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    longint ct;
    longint st;
    int unsigned p;
    int unsigned q;
    p = (idx << (24 - abits)) & 32'hffffff;
    q = p >> 22;
    x = CordicGainQ30;
    y = 0;
    z = longint'(p & 32'h3fffff);
    for (int unsigned k = 0; k < CordicN; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_turn24(k);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_turn24(k);
      end
    end
    c = clamp_unit((x + 16384) >>> 15);
    s = clamp_unit((y + 16384) >>> 15);
    case (q)
      0: begin ct = c;  st = s;  end
      1: begin ct = -s; st = c;  end
      2: begin ct = -c; st = -s; end
      default: begin ct = s; st = -c; end
    endcase
    ct = -ct;
    return {st[15:0], ct[15:0]};
  endfunction

endpackage

>>> rtl/core/gradient_noise_2d_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_top
// fixed-point 2d perlin gradient noise, when not stalled one sample per clock
// ----------------------------------------------------------------------------
// Takes one Q16.16 point (x, y) per word and returns one saturated Q1.15
// noise value per word. The datapath is a fully pipelined chain of nine
// register stages, the last of which is the output register, so a new word
// is accepted every cycle while the output is not stalled; the depth is set
// by the corner hash, which needs three chained 32-bit multiplies. The whole
// pipeline advances together under a single enable: while a result waits at
// the output, every stage holds and the input is not ready, and input is
// ready again in the cycle the waiting result is taken.
// The seed register is written through its own channel and must only change
// while the pipeline is empty.
module gradient_noise_2d_top #(
  parameter int unsigned ANGLE_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] coord_x, [63:32] coord_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] noise_value
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i      // noise_seed
);
  import gn2d_pkg::*;

  localparam int unsigned NStg = 9;
  localparam int unsigned TblN = 2 ** ANGLE_BITS;

  // constant gradient table, {gy, gx}
  function automatic logic [31:0] grad_lut(input logic [ANGLE_BITS-1:0] i);
    logic [31:0] t [TblN];
    for (int unsigned k = 0; k < TblN; k++) t[k] = grad_entry(k, ANGLE_BITS);
    return t[i];
  endfunction

  logic [31:0] seed_q;
  logic        en;
  logic [NStg-1:0] vld_q;
  logic [15:0] out_q;

  // pipeline moves whenever the output slot is free or being taken
  assign en            = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 1: cell, fraction, hash row multiply
  logic [31:0] cx0, cy0;
  logic [15:0] fx0, fy0;
  logic [31:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [16:0] fx_q [6];
  logic signed [16:0] fy_q [6];
  logic [31:0] n_q [4];

  always_comb begin
    cx0 = 32'($signed(s_axis_tdata[31:0]) >>> FRAC_BITS);
    cy0 = 32'($signed(s_axis_tdata[63:32]) >>> FRAC_BITS);
    if (FRAC_BITS >= 15) begin
      fx0 = 16'(s_axis_tdata[FRAC_BITS-1:0] >> (FRAC_BITS - 15));
      fy0 = 16'(s_axis_tdata[32+FRAC_BITS-1 -: FRAC_BITS] >> (FRAC_BITS - 15));
    end else begin
      fx0 = 16'({16'd0, s_axis_tdata[FRAC_BITS-1:0]} << (15 - FRAC_BITS));
      fy0 = 16'({16'd0, s_axis_tdata[32+FRAC_BITS-1 -: FRAC_BITS]} << (15 - FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= cx0;
      x1_q <= cx0 + 32'd1;
      y0_q <= cy0 * HashMulY;
      y1_q <= (cy0 + 32'd1) * HashMulY;
      fx_q[0] <= {1'b0, fx0};
      fy_q[0] <= {1'b0, fy0};
      for (int s = 1; s < 6; s++) begin
        fx_q[s] <= fx_q[s-1];
        fy_q[s] <= fy_q[s-1];
      end
    end
  end

  // ---- stage 2..5: corner hashes (tl, tr, bl, br)
  logic [31:0] na [4];
  logic [31:0] nn_q [4];
  logic [31:0] sq_q [4];
  logic [31:0] pk_q [4];
  logic [30:0] h_q  [4];
  // keep n aligned with pk (one stage later than nn_q)
  logic [31:0] nn_q_d [4];
  always_comb begin
    na[0] = x0_q + seed_q + y0_q;
    na[1] = x1_q + seed_q + y0_q;
    na[2] = x0_q + seed_q + y1_q;
    na[3] = x1_q + seed_q + y1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        n_q[c]  <= (na[c] << 13) ^ na[c];
        sq_q[c] <= 32'(n_q[c] * n_q[c]);
        nn_q[c] <= n_q[c];
        pk_q[c] <= 32'(sq_q[c] * HashK1) + HashK2;
        h_q[c]  <= 31'(32'(nn_q_d[c] * pk_q[c]) + HashK3);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) nn_q_d[c] <= nn_q[c];
    end
  end

  // ---- stage 6: gradient lookup; stage 7: dot products
  logic signed [15:0] gx_q [4];
  logic signed [15:0] gy_q [4];
  logic signed [16:0] fade_t2_q [2];
  logic signed [19:0] fade_u_q  [2];
  always_ff @(posedge clk_i) begin
    logic [31:0] g;
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        g = grad_lut(h_q[c][30 -: ANGLE_BITS]);
        gx_q[c] <= g[15:0];
        gy_q[c] <= g[31:16];
      end
    end
  end

  logic signed [17:0] dx [4];
  logic signed [17:0] dy [4];
  logic signed [17:0] dot_q [4];
  always_comb begin
    dx[0] = 18'(fx_q[5]); dx[2] = 18'(fx_q[5]);
    dx[1] = 18'(fx_q[5]) - 18'sd32768; dx[3] = dx[1];
    dy[0] = 18'(fy_q[5]); dy[1] = 18'(fy_q[5]);
    dy[2] = 18'(fy_q[5]) - 18'sd32768; dy[3] = dy[2];
  end
  always_ff @(posedge clk_i) begin
    logic signed [35:0] sum;
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        sum = 36'(gx_q[c] * dx[c]) + 36'(gy_q[c] * dy[c]) + 36'sd16384;
        dot_q[c] <= 18'(sum >>> 15);
      end
    end
  end

  // fade runs alongside the hash: t2/u at stage 2 input, t3 next, s after
  // u spans 1.0 to 10.0 in Q15, so it needs 20 bits
  logic signed [16:0] t3_q [2];
  logic signed [19:0] u2_q [2];
  logic signed [16:0] s_q  [2];
  logic signed [16:0] s2_q [2];
  logic signed [16:0] sv_q [2];
  always_ff @(posedge clk_i) begin
    logic signed [16:0] t;
    logic signed [35:0] p;
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        t = (a == 0) ? fx_q[0] : fy_q[0];
        p = 36'(t * t) + 36'sd16384;
        fade_t2_q[a] <= 17'(p >>> 15);
        p = 36'(t * (36'(t) * 6 - 36'sd491520)) + 36'sd16384;
        fade_u_q[a] <= 20'((p >>> 15) + 36'sd327680);
        t = (a == 0) ? fx_q[1] : fy_q[1];
        p = 36'(fade_t2_q[a] * t) + 36'sd16384;
        t3_q[a] <= 17'(p >>> 15);
        u2_q[a] <= fade_u_q[a];
        p = 36'(t3_q[a] * u2_q[a]) + 36'sd16384;
        s_q[a]  <= 17'(p >>> 15);
        s2_q[a] <= s_q[a];
        sv_q[a] <= s2_q[a];
      end
    end
  end
  // sv_q valid at stage 6; hold for lerp stages
  logic signed [16:0] sx7_q, sy7_q, sy8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx7_q <= sv_q[0];
      sy7_q <= sv_q[1];
      sy8_q <= sy7_q;
    end
  end

  // ---- stage 8: x lerps; stage 9: y lerp with saturation
  logic signed [18:0] top_q, bot_q;
  always_ff @(posedge clk_i) begin
    logic signed [37:0] p;
    if (en) begin
      p = 38'(sx7_q * (19'(dot_q[1]) - 19'(dot_q[0]))) + 38'sd16384;
      top_q <= 19'(dot_q[0]) + 19'(p >>> 15);
      p = 38'(sx7_q * (19'(dot_q[3]) - 19'(dot_q[2]))) + 38'sd16384;
      bot_q <= 19'(dot_q[2]) + 19'(p >>> 15);
    end
  end

  logic signed [19:0] v;
  always_comb begin
    logic signed [39:0] p;
    p = 40'(sy8_q * (20'(bot_q) - 20'(top_q))) + 40'sd16384;
    v = 20'(top_q) + 20'(p >>> 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en) begin
      if (v > 20'sd32767) out_q <= 16'h7fff;
      else if (v < -20'sd32768) out_q <= 16'h8000;
      else out_q <= v[15:0];
    end
  end

endmodule
